// ===== rtl/assert_macros.svh =====
// Assertion helpers, all clocked on aclk and quiet while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/cfd_pkg.sv =====
`timescale 1ns / 1ps

package cfd_pkg;

    localparam logic [7:0] START_MARKER_RESET = 8'd17;

    // deframer phases; the unused code is handled as PH_HUNT
    localparam logic [2:0] PH_HUNT    = 3'd0;
    localparam logic [2:0] PH_CMD     = 3'd1;
    localparam logic [2:0] PH_LEN     = 3'd2;
    localparam logic [2:0] PH_SUM     = 3'd3;
    localparam logic [2:0] PH_WSUM    = 3'd4;
    localparam logic [2:0] PH_HCHK    = 3'd5;
    localparam logic [2:0] PH_PAYLOAD = 3'd6;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_START = 2'd1;
    localparam logic [1:0] ST_BAD_HDR   = 2'd2;
    localparam logic [1:0] ST_BAD_DATA  = 2'd3;

    typedef struct packed {
        logic       has_data;
        logic [7:0] data_byte;
        logic [7:0] data_index;
        logic       frame_end;
        logic [1:0] status;
        logic [7:0] command;
        logic [7:0] length;
    } res_t;

endpackage

// ===== rtl/checked_frame_deframer.sv =====
`timescale 1ns / 1ps

// Checked frame deframer. Takes one link byte per beat on s_ and delivers at
// most one result beat per input byte on m_: each payload byte with its index,
// and a closing beat (m_tlast) per frame or error with status, command and
// length. Header bytes before the check byte produce no result. Each byte is
// decoded as it is accepted and lands in the single output register, so
// throughput is one byte per clock unless stalled. s_tready drops only while
// that output register holds a result that m_tready has not taken. The start
// marker (reset 17) is written through the cfg_ channel, which is always
// ready and must only be used while idle.
module checked_frame_deframer
    import cfd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,      // start_marker

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // rx_byte

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,       // data_byte, data_index, command, length
    output logic [2:0]  m_tuser,       // has_data, status[1:0]
    output logic        m_tlast        // frame_end
);

    logic [7:0] marker_reg;
    logic [2:0] phase_reg,    phase_next;
    logic [7:0] cmd_reg,      cmd_next;
    logic [7:0] len_reg,      len_next;
    logic [7:0] exp_sum_reg,  exp_sum_next;
    logic [7:0] exp_wsum_reg, exp_wsum_next;
    logic [7:0] hdr_sum_reg,  hdr_sum_next;
    logic [7:0] run_sum_reg,  run_sum_next;
    logic [7:0] run_wsum_reg, run_wsum_next;
    logic [7:0] count_reg,    count_next;

    logic       m_valid_reg;
    res_t       res_reg, res_next;
    logic       res_fire;

    logic       s_fire;
    logic [7:0] idx_inc;
    logic [15:0] wprod;
    logic [8:0] count_wide;

    assign cfg_ready = 1'b1;
    assign s_tready  = ~m_valid_reg | m_tready;
    assign s_fire    = s_tvalid & s_tready;

    assign idx_inc    = count_reg + 8'd1;
    assign wprod      = idx_inc * s_tdata;
    assign count_wide = {1'b0, count_reg} + 9'd1;

    always_comb begin
        phase_next    = phase_reg;
        cmd_next      = cmd_reg;
        len_next      = len_reg;
        exp_sum_next  = exp_sum_reg;
        exp_wsum_next = exp_wsum_reg;
        hdr_sum_next  = hdr_sum_reg;
        run_sum_next  = run_sum_reg;
        run_wsum_next = run_wsum_reg;
        count_next    = count_reg;
        res_fire      = 1'b0;
        res_next      = '0;

        case (phase_reg)
            PH_CMD: begin
                cmd_next     = s_tdata;
                hdr_sum_next = s_tdata;
                phase_next   = PH_LEN;
            end
            PH_LEN: begin
                len_next     = s_tdata;
                hdr_sum_next = hdr_sum_reg + s_tdata;
                phase_next   = PH_SUM;
            end
            PH_SUM: begin
                exp_sum_next = s_tdata;
                hdr_sum_next = hdr_sum_reg + s_tdata;
                phase_next   = PH_WSUM;
            end
            PH_WSUM: begin
                exp_wsum_next = s_tdata;
                hdr_sum_next  = hdr_sum_reg + s_tdata;
                phase_next    = PH_HCHK;
            end
            PH_HCHK: begin
                res_next.command = cmd_reg;
                res_next.length  = len_reg;
                if (s_tdata != hdr_sum_reg) begin
                    phase_next         = PH_HUNT;
                    res_fire           = 1'b1;
                    res_next.frame_end = 1'b1;
                    res_next.status    = ST_BAD_HDR;
                end else begin
                    run_sum_next  = '0;
                    run_wsum_next = '0;
                    count_next    = '0;
                    if (len_reg == 8'd0) begin
                        // empty payload closes at once, sums unchecked
                        phase_next         = PH_HUNT;
                        res_fire           = 1'b1;
                        res_next.frame_end = 1'b1;
                        res_next.status    = ST_OK;
                    end else begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                run_sum_next        = run_sum_reg + s_tdata;
                run_wsum_next       = run_wsum_reg + wprod[7:0];
                count_next          = idx_inc;
                res_fire            = 1'b1;
                res_next.has_data   = 1'b1;
                res_next.data_byte  = s_tdata;
                res_next.data_index = count_reg;
                res_next.command    = cmd_reg;
                res_next.length     = len_reg;
                if (count_wide >= {1'b0, len_reg}) begin
                    phase_next         = PH_HUNT;
                    res_next.frame_end = 1'b1;
                    res_next.status    = (run_sum_next == exp_sum_reg &&
                                          run_wsum_next == exp_wsum_reg) ?
                                         ST_OK : ST_BAD_DATA;
                end
            end
            default: begin
                if (s_tdata == marker_reg) begin
                    phase_next = PH_CMD;
                end else begin
                    // stray byte is dropped after the error beat
                    phase_next         = PH_HUNT;
                    res_fire           = 1'b1;
                    res_next.frame_end = 1'b1;
                    res_next.status    = ST_BAD_START;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            marker_reg   <= START_MARKER_RESET;
            phase_reg    <= PH_HUNT;
            cmd_reg      <= '0;
            len_reg      <= '0;
            exp_sum_reg  <= '0;
            exp_wsum_reg <= '0;
            hdr_sum_reg  <= '0;
            run_sum_reg  <= '0;
            run_wsum_reg <= '0;
            count_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                marker_reg <= cfg_data;
            end
            if (s_fire) begin
                phase_reg    <= phase_next;
                cmd_reg      <= cmd_next;
                len_reg      <= len_next;
                exp_sum_reg  <= exp_sum_next;
                exp_wsum_reg <= exp_wsum_next;
                hdr_sum_reg  <= hdr_sum_next;
                run_sum_reg  <= run_sum_next;
                run_wsum_reg <= run_wsum_next;
                count_reg    <= count_next;
            end
            if (s_fire) begin
                m_valid_reg <= res_fire;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && res_fire) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {res_reg.length, res_reg.command, res_reg.data_index,
                       res_reg.data_byte};
    assign m_tuser  = {res_reg.status, res_reg.has_data};
    assign m_tlast  = res_reg.frame_end;

`include "assert_macros.svh"

    `ASSERT_NOW(a_nodata_ends, m_valid_reg && !res_reg.has_data, res_reg.frame_end, "result without data must close a frame")
    `ASSERT_NOW(a_mid_ok, m_valid_reg && !res_reg.frame_end, res_reg.status == ST_OK, "status set on a mid-frame beat")
    `ASSERT_NOW(a_payload_len, phase_reg == PH_PAYLOAD, len_reg != 8'd0, "payload phase with zero length")
    `ASSERT_NEXT(a_marker_opens, s_fire && phase_reg == PH_HUNT && s_tdata == marker_reg, phase_reg == PH_CMD, "start marker did not open a header")
    `ASSERT_NEXT(a_hdr_silent, s_fire && (phase_reg == PH_CMD || phase_reg == PH_LEN || phase_reg == PH_SUM || phase_reg == PH_WSUM), !m_valid_reg, "header byte produced a result")

endmodule

// ===== bench/checked_frame_deframer_tb.sv =====
`timescale 1ns / 1ps

module checked_frame_deframer_tb;
    import cfd_pkg::*;

    localparam int STUCK_LIMIT  = 1000;
    localparam int PHASE_BYTES  = 270;
    localparam int NUM_PHASES   = 6;
    localparam int DIRECTED_LEN = 29;

    typedef enum logic [1:0] {
        RK_QUIET,   // header byte, nothing may come out
        RK_TYPED,   // result written out in the row
        RK_PRED     // result from the deframer model
    } row_kind_t;

    typedef struct packed {
        row_kind_t  kind;
        logic [7:0] val;
        res_t       want;
    } row_t;

    localparam res_t NO_RESULT = '0;

    // marker is at its reset value (8'h11) throughout this table
    localparam row_t DIRECTED [DIRECTED_LEN] = '{
        '{RK_TYPED, 8'h00, '{1'b0, 8'h00, 8'h00, 1'b1, ST_BAD_START, 8'h00, 8'h00}},
        // zero-length frame closes right on the header check
        '{RK_QUIET, 8'h11, NO_RESULT},
        '{RK_QUIET, 8'hA5, NO_RESULT},
        '{RK_QUIET, 8'h00, NO_RESULT},
        '{RK_QUIET, 8'h00, NO_RESULT},
        '{RK_QUIET, 8'h00, NO_RESULT},
        '{RK_TYPED, 8'hA5, '{1'b0, 8'h00, 8'h00, 1'b1, ST_OK, 8'hA5, 8'h00}},
        // header checksum should be 8'h0A
        '{RK_QUIET, 8'h11, NO_RESULT},
        '{RK_QUIET, 8'h01, NO_RESULT},
        '{RK_QUIET, 8'h02, NO_RESULT},
        '{RK_QUIET, 8'h03, NO_RESULT},
        '{RK_QUIET, 8'h04, NO_RESULT},
        '{RK_TYPED, 8'h00, '{1'b0, 8'h00, 8'h00, 1'b1, ST_BAD_HDR, 8'h01, 8'h02}},
        // good two-byte frame
        '{RK_QUIET, 8'h11, NO_RESULT},
        '{RK_QUIET, 8'h3C, NO_RESULT},
        '{RK_QUIET, 8'h02, NO_RESULT},
        '{RK_QUIET, 8'hFF, NO_RESULT},
        '{RK_QUIET, 8'hFF, NO_RESULT},
        '{RK_QUIET, 8'h3C, NO_RESULT},
        '{RK_PRED,  8'hFF, NO_RESULT},
        '{RK_PRED,  8'h00, NO_RESULT},
        // one-byte frame, sums declared as zero
        '{RK_QUIET, 8'h11, NO_RESULT},
        '{RK_QUIET, 8'h00, NO_RESULT},
        '{RK_QUIET, 8'h01, NO_RESULT},
        '{RK_QUIET, 8'h00, NO_RESULT},
        '{RK_QUIET, 8'h00, NO_RESULT},
        '{RK_QUIET, 8'h01, NO_RESULT},
        '{RK_TYPED, 8'h80, '{1'b1, 8'h80, 8'h00, 1'b1, ST_BAD_DATA, 8'h00, 8'h01}},
        '{RK_TYPED, 8'hFF, '{1'b0, 8'h00, 8'h00, 1'b1, ST_BAD_START, 8'h00, 8'h00}}
    };

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;      // rx_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;      // data_byte, data_index, command, length
    logic [2:0]  m_tuser;      // has_data, status[1:0]
    logic        m_tlast;      // frame_end

    checked_frame_deframer u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // deframer model state
    logic [7:0] dfr_marker;
    logic [2:0] dfr_phase;
    logic [7:0] dfr_cmd;
    logic [7:0] dfr_len;
    logic [7:0] dfr_sum_want;
    logic [7:0] dfr_wsum_want;
    logic [7:0] dfr_hdr_sum;
    logic [7:0] dfr_sum;
    logic [7:0] dfr_wsum;
    logic [7:0] dfr_count;

    res_t pending_results[$];
    res_t head;
    int   errors;
    int   stuck;
    bit   calm;
    int   gap_pct;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    task automatic deframe_byte(input logic [7:0] b, output bit fired, output res_t r);
        logic [15:0] w;
        fired = 1'b0;
        r     = NO_RESULT;
        case (dfr_phase)
            PH_CMD: begin
                dfr_cmd     = b;
                dfr_hdr_sum = b;
                dfr_phase   = PH_LEN;
            end
            PH_LEN: begin
                dfr_len     = b;
                dfr_hdr_sum = dfr_hdr_sum + b;
                dfr_phase   = PH_SUM;
            end
            PH_SUM: begin
                dfr_sum_want = b;
                dfr_hdr_sum  = dfr_hdr_sum + b;
                dfr_phase    = PH_WSUM;
            end
            PH_WSUM: begin
                dfr_wsum_want = b;
                dfr_hdr_sum   = dfr_hdr_sum + b;
                dfr_phase     = PH_HCHK;
            end
            PH_HCHK: begin
                fired = 1'b1;
                r = '{1'b0, 8'h00, 8'h00, 1'b1, ST_BAD_HDR, dfr_cmd, dfr_len};
                dfr_phase = PH_HUNT;
                if (b == dfr_hdr_sum) begin
                    dfr_sum   = '0;
                    dfr_wsum  = '0;
                    dfr_count = '0;
                    r.status  = ST_OK;
                    // empty payload closes at once, sums not checked
                    fired = (dfr_len == 8'd0);
                    if (dfr_len != 8'd0)
                        dfr_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                w        = ({8'd0, dfr_count} + 16'd1) * {8'd0, b};
                dfr_sum  = dfr_sum + b;
                dfr_wsum = dfr_wsum + w[7:0];
                fired    = 1'b1;
                r = '{1'b1, b, dfr_count, 1'b0, ST_OK, dfr_cmd, dfr_len};
                if ({1'b0, dfr_count} + 9'd1 >= {1'b0, dfr_len}) begin
                    r.frame_end = 1'b1;
                    if (dfr_sum != dfr_sum_want || dfr_wsum != dfr_wsum_want)
                        r.status = ST_BAD_DATA;
                    dfr_phase = PH_HUNT;
                end
                dfr_count = dfr_count + 8'd1;
            end
            default: begin
                if (b == dfr_marker) begin
                    dfr_phase = PH_CMD;
                end else begin
                    dfr_phase = PH_HUNT;
                    fired = 1'b1;
                    r = '{1'b0, 8'h00, 8'h00, 1'b1, ST_BAD_START, 8'h00, 8'h00};
                end
            end
        endcase
    endtask

    // drive one byte, return once it has been taken
    task automatic push_byte(input logic [7:0] b);
        if (!calm && $urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_predicted(input logic [7:0] b);
        bit   fired;
        res_t r;
        push_byte(b);
        deframe_byte(b, fired, r);
        if (fired)
            pending_results.push_back(r);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        // header bytes leave nothing behind to wait on
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_marker(input logic [7:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid  <= 1'b0;
        dfr_marker = v;
    endtask

    task automatic run_traffic(input int budget, input bit big_first);
        logic [7:0] burst[$];
        logic [7:0] len, cmd, sum, wsum, hchk, pb;
        logic [15:0] w;
        int pick, sent, n;
        bit big;
        sent = 0;
        big  = big_first;
        while (sent < budget) begin
            burst.delete();
            pick = $urandom_range(0, 99);
            case ($urandom_range(0, 2))
                0: gap_pct = 0;
                1: gap_pct = 10;
                default: gap_pct = 40;
            endcase
            if (pick < 12) begin
                repeat ($urandom_range(1, 4)) burst.push_back(8'($urandom_range(0, 255)));
            end else begin
                if (big) begin
                    len = 8'd255;
                end else begin
                    n = $urandom_range(0, 19);
                    if (n == 0)
                        len = 8'd0;
                    else if (n < 18)
                        len = 8'($urandom_range(1, 8));
                    else
                        len = 8'($urandom_range(9, 40));
                end
                big  = 1'b0;
                cmd  = 8'($urandom_range(0, 255));
                sum  = '0;
                wsum = '0;
                for (int i = 0; i < len; i++) begin
                    pb = 8'($urandom_range(0, 255));
                    w  = (16'(i) + 16'd1) * {8'd0, pb};
                    sum  = sum + pb;
                    wsum = wsum + w[7:0];
                    burst.push_back(pb);
                end
                // corrupt the declared sums now and then
                if ($urandom_range(0, 99) < 15) begin
                    if ($urandom_range(0, 1))
                        sum = sum + 8'($urandom_range(1, 255));
                    else
                        wsum = wsum + 8'($urandom_range(1, 255));
                end
                hchk = cmd + len + sum + wsum;
                if ($urandom_range(0, 99) < 10)
                    hchk = hchk + 8'($urandom_range(1, 255));
                burst.push_front(hchk);
                burst.push_front(wsum);
                burst.push_front(sum);
                burst.push_front(len);
                burst.push_front(cmd);
                burst.push_front(dfr_marker);
                // truncated frame: the next frame gets swallowed as its tail
                if ($urandom_range(0, 99) < 5)
                    repeat ($urandom_range(1, burst.size() - 1)) void'(burst.pop_back());
            end
            foreach (burst[i]) begin
                send_predicted(burst[i]);
                sent++;
            end
        end
    endtask

    initial begin
        bit   fired;
        res_t r;
        logic [7:0] markers [NUM_PHASES];
        markers[0] = 8'h00;
        markers[1] = 8'hFF;
        markers[2] = 8'($urandom_range(1, 254));
        markers[3] = START_MARKER_RESET;
        markers[4] = 8'($urandom_range(0, 255));
        markers[5] = 8'h5A;

        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        errors    = 0;
        calm      = 1'b0;
        gap_pct   = 20;

        dfr_marker    = START_MARKER_RESET;
        dfr_phase     = PH_HUNT;
        dfr_cmd       = '0;
        dfr_len       = '0;
        dfr_sum_want  = '0;
        dfr_wsum_want = '0;
        dfr_hdr_sum   = '0;
        dfr_sum       = '0;
        dfr_wsum      = '0;
        dfr_count     = '0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIRECTED_LEN; i++) begin
            push_byte(DIRECTED[i].val);
            deframe_byte(DIRECTED[i].val, fired, r);
            case (DIRECTED[i].kind)
                RK_TYPED: pending_results.push_back(DIRECTED[i].want);
                RK_PRED: begin
                    if (fired)
                        pending_results.push_back(r);
                end
                default: ;
            endcase
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            if (p == NUM_PHASES - 1)
                calm = 1'b1;
            write_marker(markers[p]);
            run_traffic(PHASE_BYTES, p == 1 || p == 3);
        end

        drain();
        repeat (8) @(posedge aclk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result side back-pressure
    initial begin
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (calm) begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end else if ($urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
        end
    end

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result beat with nothing expected, actual data %h user %h last %b",
                         $time, m_tdata, m_tuser, m_tlast);
                errors++;
            end else begin
                head = pending_results.pop_front();
                check_field("has_data",   8'(head.has_data),  8'(m_tuser[0]));
                check_field("data_byte",  head.data_byte,     m_tdata[7:0]);
                check_field("data_index", head.data_index,    m_tdata[15:8]);
                check_field("frame_end",  8'(head.frame_end), 8'(m_tlast));
                check_field("status",     8'(head.status),    8'(m_tuser[2:1]));
                check_field("command",    head.command,       m_tdata[23:16]);
                check_field("length",     head.length,        m_tdata[31:24]);
            end
        end
    end

    // ends the run if no beat moves on any channel for too long
    initial begin
        stuck = 0;
        while (stuck < STUCK_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                stuck = 0;
            else
                stuck++;
        end
        $display("%0t: no beat accepted for %0d cycles", $time, STUCK_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
